### rtl/core/mtrc_pkg.sv
// ----------------------------------------------------------------------------
// mtrc_pkg
// shared types and codes for the multicast file transfer receive control
// ----------------------------------------------------------------------------
`default_nettype none

package mtrc_pkg;

  localparam int MAP_WORDS_DEF = 2048;
  localparam int WORD_BITS_DEF = 32;

  localparam logic [2:0] OP_START   = 3'd0;
  localparam logic [2:0] OP_TIMEOUT = 3'd1;
  localparam logic [2:0] OP_DATA    = 3'd2;
  localparam logic [2:0] OP_ERROR   = 3'd3;
  localparam logic [2:0] OP_DISCARD = 3'd4;
  localparam logic [2:0] OP_FATAL   = 3'd5;
  localparam logic [2:0] OP_CANCEL  = 3'd6;
  localparam logic [2:0] OP_REQFAIL = 3'd7;

  localparam logic [2:0] ACT_WAIT  = 3'd0;
  localparam logic [2:0] ACT_REQ   = 3'd1;
  localparam logic [2:0] ACT_ACK   = 3'd2;
  localparam logic [2:0] ACT_ERR   = 3'd3;
  localparam logic [2:0] ACT_WRITE = 3'd4;
  localparam logic [2:0] ACT_OK    = 3'd5;
  localparam logic [2:0] ACT_ABORT = 3'd6;

  localparam logic [15:0] ERR_UNDEF     = 16'd0;
  localparam logic [15:0] ERR_DISK_FULL = 16'd3;

  localparam logic [1:0] REG_LISTEN_WAIT = 2'd0;
  localparam logic [1:0] REG_REPLY_WAIT  = 2'd1;
  localparam logic [1:0] REG_RETRY_LIMIT = 2'd2;

  localparam logic [4:0] RETRY_MAX = 5'd31;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_WAIT = 2'd1,
    PH_DONE = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    LM_LISTEN  = 2'd0,
    LM_OPEN    = 2'd1,
    LM_RECEIVE = 2'd2
  } mode_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECIDE,
    ST_MARK_RD,
    ST_MARK_WR,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

### rtl/core/mtrc_ram.sv
// ----------------------------------------------------------------------------
// mtrc_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module mtrc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/core/multicast_tftp_receive_control_core.sv
// ----------------------------------------------------------------------------
// multicast_tftp_receive_control_core
// client side control of a multicast trivial file transfer
// ----------------------------------------------------------------------------
// Events come in on the s_ stream (opcode in s_tuser, packet flags and block
// number in s_tdata). Each event gives zero to three actions on the m_ stream
// (action in m_tuser, value in m_tdata, m_tlast on the final action of the
// event). Registers are to be written over the cfg_ channel only while the
// block is idle; the block itself does not enforce this. One event is taken
// at a time; s_tready is low until its last action has been loaded into the
// output register. A data event that marks the bitmap adds a read and a
// write of its word; word and bit come from a shift and a mask of the block
// number, so WORD_BITS is to be a power of two, which the block does not
// check. In listen mode with the final block known it then scans the
// bitmap word by word through the single read port, reading and then
// checking each word. A start event clears the bitmap, one word per cycle.
// After reset the same clearing pass runs before the first event is taken;
// config writes are taken throughout. A stalled m_tready just holds the
// current action and pauses the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module multicast_tftp_receive_control_core #(
  parameter int MAP_WORDS = mtrc_pkg::MAP_WORDS_DEF,
  parameter int WORD_BITS = mtrc_pkg::WORD_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // tdata: block_num[15:0], short_block, from_server, on_unicast, write_failed
  input  wire logic [23:0] s_tdata,
  // tuser: opcode[2:0]
  input  wire logic [2:0]  s_tuser,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // tdata: value[15:0]
  output logic      [15:0] m_tdata,
  // tuser: action[2:0]
  output logic      [2:0]  m_tuser,
  output logic             m_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  localparam int ADDR_W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BIT_SH = $clog2(WORD_BITS);
  localparam int BIT_W = $clog2(WORD_BITS) + 1;
  localparam int MAP_BITS = MAP_WORDS * WORD_BITS;
  localparam int BASE_W0 = $clog2(MAP_BITS + 1);
  localparam int BASE_W = (BASE_W0 > 17) ? BASE_W0 : 17;

  mtrc_pkg::state_t st, st_next;

  // config
  logic [7:0] listen_wait, reply_wait;
  logic [3:0] retry_limit;

  // transfer state
  mtrc_pkg::phase_t phase, phase_next;
  mtrc_pkg::mode_t  link_mode, link_mode_next;
  logic [15:0] current_block, current_block_next;
  logic        final_known, final_known_next;
  logic [15:0] final_block, final_block_next;
  logic [4:0]  retry_count, retry_count_next;
  logic        resend_ack, resend_ack_next;
  logic        heard_any, heard_any_next;
  logic [7:0]  wait_now, wait_now_next;

  // latched event
  logic [2:0]  ev_op;
  logic [15:0] ev_blk;
  logic        ev_short, ev_from, ev_uni, ev_wf;

  // action list
  logic [2:0]  list_act [4];
  logic [15:0] list_val [4];
  logic [2:0]  list_n;
  logic [1:0]  emit_idx;
  logic        need_mark, need_scan, clr_emit;

  // decision outputs
  logic [2:0]  d_act [4];
  logic [15:0] d_val [4];
  logic [2:0]  d_n;
  logic        d_start, d_mark, d_scan;
  logic [4:0]  rc_inc;
  logic        rc_over;

  // bitmap position of the block
  logic [15:0] mark_idx, mark_word;

  // scan
  logic [ADDR_W:0]      scan_w;
  logic [BASE_W-1:0]    scan_base, scan_lim, scan_rem;
  logic [WORD_BITS-1:0] scan_mask;
  logic                 scan_hit_end, scan_beyond, scan_word_ok;

  // clear and ram
  logic [ADDR_W-1:0]    clr_addr;
  logic                 clr_last;
  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata, ram_rdata, mark_bit;

  logic in_xfer, out_free, out_load, out_last_sel, mark_in_map;

  assign in_xfer  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign cfg_ready = 1'b1;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      listen_wait <= 8'd2;
      reply_wait  <= 8'd2;
      retry_limit <= 4'd3;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mtrc_pkg::REG_LISTEN_WAIT: listen_wait <= cfg_data;
        mtrc_pkg::REG_REPLY_WAIT:  reply_wait <= cfg_data;
        mtrc_pkg::REG_RETRY_LIMIT: retry_limit <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // event decision
  assign rc_inc  = (retry_count < mtrc_pkg::RETRY_MAX) ? retry_count + 5'd1 : retry_count;
  assign rc_over = rc_inc > {1'b0, retry_limit};

  always_comb begin
    mtrc_pkg::mode_t m2;
    logic            fk2;
    logic [15:0]     fb2;
    phase_next         = phase;
    link_mode_next     = link_mode;
    current_block_next = current_block;
    final_known_next   = final_known;
    final_block_next   = final_block;
    retry_count_next   = retry_count;
    resend_ack_next    = resend_ack;
    heard_any_next     = heard_any;
    wait_now_next      = wait_now;
    for (int i = 0; i < 4; i++) begin
      d_act[i] = mtrc_pkg::ACT_WAIT;
      d_val[i] = '0;
    end
    d_n     = '0;
    d_start = 1'b0;
    d_mark  = 1'b0;
    d_scan  = 1'b0;
    m2      = link_mode;
    fk2     = final_known;
    fb2     = final_block;
    if (ev_op == mtrc_pkg::OP_START) begin
      d_start            = 1'b1;
      phase_next         = mtrc_pkg::PH_WAIT;
      link_mode_next     = mtrc_pkg::LM_LISTEN;
      current_block_next = '0;
      final_known_next   = 1'b0;
      final_block_next   = '0;
      retry_count_next   = '0;
      resend_ack_next    = 1'b0;
      heard_any_next     = 1'b0;
      wait_now_next      = listen_wait;
      d_act[0] = mtrc_pkg::ACT_WAIT; d_val[0] = {8'd0, listen_wait}; d_n = 3'd1;
    end else if (phase == mtrc_pkg::PH_WAIT) begin
      case (ev_op)
        mtrc_pkg::OP_TIMEOUT: begin
          retry_count_next = rc_inc;
          if (link_mode == mtrc_pkg::LM_LISTEN) begin
            link_mode_next     = mtrc_pkg::LM_OPEN;
            current_block_next = '0;
            wait_now_next      = reply_wait;
            resend_ack_next    = 1'b0;
            d_act[0] = mtrc_pkg::ACT_REQ;  d_val[0] = '0;
            d_act[1] = mtrc_pkg::ACT_WAIT; d_val[1] = {8'd0, reply_wait};
            d_n = 3'd2;
          end else if (rc_over) begin
            phase_next = mtrc_pkg::PH_DONE;
            d_act[0] = mtrc_pkg::ACT_ABORT; d_n = 3'd1;
          end else if (resend_ack) begin
            d_act[0] = mtrc_pkg::ACT_ACK; d_val[0] = current_block;
            if (final_known && current_block == final_block) begin
              phase_next = mtrc_pkg::PH_DONE;
              d_act[1] = mtrc_pkg::ACT_OK;
            end else begin
              d_act[1] = mtrc_pkg::ACT_WAIT; d_val[1] = {8'd0, wait_now};
            end
            d_n = 3'd2;
          end else begin
            d_act[0] = mtrc_pkg::ACT_REQ;
            d_act[1] = mtrc_pkg::ACT_WAIT; d_val[1] = {8'd0, wait_now};
            d_n = 3'd2;
          end
        end
        mtrc_pkg::OP_DATA: begin
          heard_any_next = 1'b1;
          if (!ev_from) begin
            d_act[0] = mtrc_pkg::ACT_WAIT; d_val[0] = {8'd0, wait_now}; d_n = 3'd1;
          end else if (link_mode == mtrc_pkg::LM_LISTEN && ev_uni) begin
            d_act[0] = mtrc_pkg::ACT_WAIT; d_val[0] = {8'd0, wait_now}; d_n = 3'd1;
          end else begin
            if (link_mode != mtrc_pkg::LM_LISTEN) begin
              if (ev_uni) begin
                if (current_block == '0 && link_mode == mtrc_pkg::LM_OPEN) begin
                  m2 = mtrc_pkg::LM_RECEIVE;
                end
              end else if (current_block == '0) begin
                m2 = mtrc_pkg::LM_LISTEN;
              end
            end
            link_mode_next     = m2;
            retry_count_next   = '0;
            current_block_next = ev_blk;
            d_act[0] = mtrc_pkg::ACT_WRITE; d_val[0] = ev_blk;
            if (ev_wf) begin
              phase_next = mtrc_pkg::PH_DONE;
              if (m2 == mtrc_pkg::LM_RECEIVE) begin
                d_act[1] = mtrc_pkg::ACT_ERR; d_val[1] = mtrc_pkg::ERR_DISK_FULL;
                d_act[2] = mtrc_pkg::ACT_OK;
                d_n = 3'd3;
              end else begin
                d_act[1] = mtrc_pkg::ACT_OK;
                d_n = 3'd2;
              end
            end else begin
              if (ev_short) begin
                fk2 = 1'b1;
                fb2 = ev_blk;
              end
              final_known_next = fk2;
              final_block_next = fb2;
              d_mark = ev_blk != '0;
              if (m2 == mtrc_pkg::LM_LISTEN) begin
                if (fk2) begin
                  d_scan = 1'b1;
                  d_n = 3'd1;
                end else begin
                  d_act[1] = mtrc_pkg::ACT_WAIT; d_val[1] = {8'd0, wait_now};
                  d_n = 3'd2;
                end
              end else begin
                resend_ack_next = 1'b1;
                d_act[1] = mtrc_pkg::ACT_ACK; d_val[1] = ev_blk;
                if (fk2 && ev_blk == fb2) begin
                  phase_next = mtrc_pkg::PH_DONE;
                  d_act[2] = mtrc_pkg::ACT_OK;
                end else begin
                  d_act[2] = mtrc_pkg::ACT_WAIT; d_val[2] = {8'd0, wait_now};
                end
                d_n = 3'd3;
              end
            end
          end
        end
        mtrc_pkg::OP_ERROR: begin
          heard_any_next = 1'b1;
          if (link_mode == mtrc_pkg::LM_LISTEN || !ev_from) begin
            d_act[0] = mtrc_pkg::ACT_WAIT; d_val[0] = {8'd0, wait_now};
          end else begin
            phase_next = mtrc_pkg::PH_DONE;
            d_act[0] = mtrc_pkg::ACT_ABORT;
          end
          d_n = 3'd1;
        end
        mtrc_pkg::OP_DISCARD: begin
          heard_any_next   = 1'b1;
          retry_count_next = rc_inc;
          if (rc_over) begin
            phase_next = mtrc_pkg::PH_DONE;
            d_act[0] = mtrc_pkg::ACT_ABORT;
          end else begin
            d_act[0] = mtrc_pkg::ACT_WAIT; d_val[0] = {8'd0, wait_now};
          end
          d_n = 3'd1;
        end
        mtrc_pkg::OP_CANCEL: begin
          phase_next = mtrc_pkg::PH_DONE;
          if (heard_any && link_mode == mtrc_pkg::LM_RECEIVE) begin
            d_act[0] = mtrc_pkg::ACT_ERR; d_val[0] = mtrc_pkg::ERR_UNDEF;
            d_act[1] = mtrc_pkg::ACT_ABORT;
            d_n = 3'd2;
          end else begin
            d_act[0] = mtrc_pkg::ACT_ABORT;
            d_n = 3'd1;
          end
        end
        default: begin
          phase_next = mtrc_pkg::PH_DONE;
          d_act[0] = mtrc_pkg::ACT_ABORT;
          d_n = 3'd1;
        end
      endcase
    end
  end

  // word and bit of the block in the bitmap
  assign mark_idx    = ev_blk - 16'd1;
  assign mark_word   = mark_idx >> BIT_SH;
  assign mark_in_map = mark_word < 16'(MAP_WORDS);
  assign mark_bit    = WORD_BITS'(1) << mark_idx[BIT_SH-1:0];

  // scan word check
  assign scan_hit_end = scan_base >= scan_lim;
  assign scan_beyond  = scan_w == (ADDR_W+1)'(MAP_WORDS);
  assign scan_rem     = scan_lim - scan_base;
  assign scan_mask    = (scan_rem >= BASE_W'(WORD_BITS)) ? '1 :
                        ~({WORD_BITS{1'b1}} << scan_rem[BIT_W-1:0]);
  assign scan_word_ok = (ram_rdata & scan_mask) == scan_mask;

  assign clr_last     = clr_addr == ADDR_W'(MAP_WORDS - 1);
  assign out_last_sel = ({1'b0, emit_idx} + 3'd1) == list_n;

  // next state
  always_comb begin
    st_next = st;
    case (st)
      mtrc_pkg::ST_CLEAR: begin
        if (clr_last) st_next = clr_emit ? mtrc_pkg::ST_EMIT : mtrc_pkg::ST_IDLE;
      end
      mtrc_pkg::ST_IDLE: begin
        if (in_xfer) st_next = mtrc_pkg::ST_DECIDE;
      end
      mtrc_pkg::ST_DECIDE: begin
        if (d_start) st_next = mtrc_pkg::ST_CLEAR;
        else if (d_mark) st_next = mtrc_pkg::ST_MARK_RD;
        else if (d_scan) st_next = mtrc_pkg::ST_SCAN_RD;
        else if (d_n == '0) st_next = mtrc_pkg::ST_IDLE;
        else st_next = mtrc_pkg::ST_EMIT;
      end
      mtrc_pkg::ST_MARK_RD: begin
        if (mark_in_map) st_next = mtrc_pkg::ST_MARK_WR;
        else st_next = need_scan ? mtrc_pkg::ST_SCAN_RD : mtrc_pkg::ST_EMIT;
      end
      mtrc_pkg::ST_MARK_WR: begin
        st_next = need_scan ? mtrc_pkg::ST_SCAN_RD : mtrc_pkg::ST_EMIT;
      end
      mtrc_pkg::ST_SCAN_RD: begin
        if (scan_hit_end || scan_beyond) st_next = mtrc_pkg::ST_EMIT;
        else st_next = mtrc_pkg::ST_SCAN_CHK;
      end
      mtrc_pkg::ST_SCAN_CHK: begin
        st_next = scan_word_ok ? mtrc_pkg::ST_SCAN_RD : mtrc_pkg::ST_EMIT;
      end
      mtrc_pkg::ST_EMIT: begin
        if (out_free && out_last_sel) st_next = mtrc_pkg::ST_IDLE;
      end
      default: st_next = mtrc_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_tready  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = mark_word[ADDR_W-1:0];
    ram_wdata = ram_rdata | mark_bit;
    ram_raddr = scan_w[ADDR_W-1:0];
    out_load  = 1'b0;
    case (st)
      mtrc_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      mtrc_pkg::ST_IDLE:    s_tready = 1'b1;
      mtrc_pkg::ST_MARK_RD: ram_raddr = mark_word[ADDR_W-1:0];
      mtrc_pkg::ST_MARK_WR: ram_we = 1'b1;
      mtrc_pkg::ST_EMIT:    out_load = out_free;
      default: ;
    endcase
  end

  mtrc_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS),
    .ADDR_W(ADDR_W)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      st            <= mtrc_pkg::ST_CLEAR;
      clr_addr      <= '0;
      clr_emit      <= 1'b0;
      phase         <= mtrc_pkg::PH_IDLE;
      link_mode     <= mtrc_pkg::LM_LISTEN;
      current_block <= '0;
      final_known   <= 1'b0;
      final_block   <= '0;
      retry_count   <= '0;
      resend_ack    <= 1'b0;
      heard_any     <= 1'b0;
      wait_now      <= '0;
      list_n        <= '0;
      emit_idx      <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      st       <= st_next;
      m_tvalid <= out_load || (m_tvalid && !m_tready);
      case (st)
        mtrc_pkg::ST_CLEAR: clr_addr <= clr_last ? '0 : clr_addr + ADDR_W'(1);
        mtrc_pkg::ST_DECIDE: begin
          phase         <= phase_next;
          link_mode     <= link_mode_next;
          current_block <= current_block_next;
          final_known   <= final_known_next;
          final_block   <= final_block_next;
          retry_count   <= retry_count_next;
          resend_ack    <= resend_ack_next;
          heard_any     <= heard_any_next;
          wait_now      <= wait_now_next;
          list_n        <= d_n;
          emit_idx      <= '0;
          clr_emit      <= d_start;
        end
        mtrc_pkg::ST_SCAN_RD: begin
          if (scan_hit_end) begin
            phase  <= mtrc_pkg::PH_DONE;
            list_n <= list_n + 3'd1;
          end else if (scan_beyond) begin
            list_n <= list_n + 3'd1;
          end
        end
        mtrc_pkg::ST_SCAN_CHK: begin
          if (!scan_word_ok) list_n <= list_n + 3'd1;
        end
        mtrc_pkg::ST_EMIT: begin
          if (out_free) begin
            emit_idx <= emit_idx + 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      ev_op    <= s_tuser;
      ev_blk   <= s_tdata[15:0];
      ev_short <= s_tdata[16];
      ev_from  <= s_tdata[17];
      ev_uni   <= s_tdata[18];
      ev_wf    <= s_tdata[19];
    end
    case (st)
      mtrc_pkg::ST_DECIDE: begin
        for (int i = 0; i < 4; i++) begin
          list_act[i] <= d_act[i];
          list_val[i] <= d_val[i];
        end
        need_mark <= d_mark;
        need_scan <= d_scan;
        scan_w    <= '0;
        scan_base <= '0;
        scan_lim  <= (final_block_next == '0) ? BASE_W'(MAP_BITS) : BASE_W'(final_block_next);
      end
      mtrc_pkg::ST_SCAN_RD: begin
        if (scan_hit_end) begin
          list_act[list_n[1:0]] <= mtrc_pkg::ACT_OK;
          list_val[list_n[1:0]] <= '0;
        end else if (scan_beyond) begin
          list_act[list_n[1:0]] <= mtrc_pkg::ACT_WAIT;
          list_val[list_n[1:0]] <= {8'd0, wait_now};
        end
      end
      mtrc_pkg::ST_SCAN_CHK: begin
        if (scan_word_ok) begin
          scan_w    <= scan_w + (ADDR_W+1)'(1);
          scan_base <= scan_base + BASE_W'(WORD_BITS);
        end else begin
          list_act[list_n[1:0]] <= mtrc_pkg::ACT_WAIT;
          list_val[list_n[1:0]] <= {8'd0, wait_now};
        end
      end
      mtrc_pkg::ST_EMIT: begin
        if (out_load) begin
          m_tuser <= list_act[emit_idx];
          m_tdata <= list_val[emit_idx];
          m_tlast <= out_last_sel;
        end
      end
      default: ;
    endcase
  end

  // checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> !s_tready)
    else $error("event taken while previous one in progress");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    (st == mtrc_pkg::ST_CLEAR) |-> !s_tready)
    else $error("ready during bitmap clear");

  a_last_ends_event: assert property (@(posedge clk) disable iff (rst)
    (out_load && out_last_sel) |=> (st == mtrc_pkg::ST_IDLE) && m_tlast)
    else $error("last action did not end the event");

  a_mark_only_when_needed: assert property (@(posedge clk) disable iff (rst)
    (st == mtrc_pkg::ST_MARK_WR) |-> need_mark && mark_in_map)
    else $error("bitmap written without a block to mark");

endmodule

`default_nettype wire
